// ===== rtl/sha1_pkg.sv =====
`timescale 1ns / 1ps

package sha1_pkg;

    localparam int COUNT_W         = 61;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int ROUNDS          = 80;

    typedef logic [31:0] word_t;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_BYTE       = 2'd0;
    localparam kind_t KIND_CLOSE      = 2'd1;
    localparam kind_t KIND_BYTE_CLOSE = 2'd2;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } cmd_t;

    localparam word_t INIT_CHAIN [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam word_t ROUND_K [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic word_t round_f(input logic [1:0] phase, input word_t b,
                                      input word_t c, input word_t d);
        word_t f;
        unique case (phase)
            2'd0:    f = (b & c) | (~b & d);
            2'd2:    f = (b & c) | (b & d) | (c & d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

// ===== rtl/sha1_msg_if.sv =====
`timescale 1ns / 1ps

interface sha1_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       is_last;

    modport source (output valid, output data_byte, output byte_present, output is_last,
                    input ready);
    modport sink   (input valid, input data_byte, input byte_present, input is_last,
                    output ready);
endinterface

// ===== rtl/sha1_digest_if.sv =====
`timescale 1ns / 1ps

interface sha1_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input last_word,
                    output ready);
endinterface

// ===== rtl/sha1_front.sv =====
`timescale 1ns / 1ps

module sha1_front
    import sha1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sha1_msg_if.sink    msg,
    output logic        push_valid,
    output cmd_t        push_item,
    input  logic        push_ready
);

    logic slot_valid_reg, slot_valid_next;
    cmd_t slot_reg, slot_next;
    cmd_t item;
    logic take;

    assign msg.ready  = !slot_valid_reg || push_ready;
    assign push_valid = slot_valid_reg;
    assign push_item  = slot_reg;
    assign take       = msg.valid && msg.ready;

    always_comb
    begin
        item.data = msg.data_byte;
        priority if (msg.byte_present && msg.is_last)
            item.kind = KIND_BYTE_CLOSE;
        else if (msg.byte_present)
            item.kind = KIND_BYTE;
        else
            item.kind = KIND_CLOSE;

        slot_valid_next = slot_valid_reg;
        slot_next       = slot_reg;
        if (push_ready)
            slot_valid_next = 1'b0;
        // beats carrying neither byte nor close are dropped here
        if (take && (msg.byte_present || msg.is_last))
        begin
            slot_valid_next = 1'b1;
            slot_next       = item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_valid_reg <= 1'b0;
        else
            slot_valid_reg <= slot_valid_next;
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

// ===== rtl/sha1_queue.sv =====
`timescale 1ns / 1ps

module sha1_queue
    import sha1_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  cmd_t push_item,
    output logic push_ready,
    output logic pop_valid,
    output cmd_t pop_item,
    input  logic pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== rtl/sha1_back.sv =====
`timescale 1ns / 1ps

module sha1_back
    import sha1_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    input  cmd_t          pop_item,
    output logic          pop_ready,
    sha1_digest_if.source digest
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam logic [1:0] BLK_DATA  = 2'd0;
    localparam logic [1:0] BLK_PAD1  = 2'd1;
    localparam logic [1:0] BLK_FINAL = 2'd2;

    localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);

    logic [2:0]         state_reg, state_next;
    logic [1:0]         blk_reg, blk_next;
    logic               close_pend_reg, close_pend_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    word_t              chain_reg [5];
    word_t              chain_next [5];
    logic [6:0]         round_reg, round_next;
    logic [2:0]         emit_reg, emit_next;
    logic               out_valid_reg, out_valid_next;

    word_t              win_reg [16];
    word_t              win_next [16];
    word_t              work_reg [5];
    word_t              work_next [5];
    word_t              out_word_reg, out_word_next;
    logic [2:0]         out_idx_reg, out_idx_next;
    logic               out_last_reg, out_last_next;

    logic               pop;
    logic               out_load;
    logic [5:0]         pos;
    logic [1:0]         phase;
    word_t              w_cur, temp, mix;
    word_t              len_hi, len_lo;
    word_t              sum [5];

    assign pop_ready          = (state_reg == S_IDLE);
    assign pop                = pop_valid && pop_ready;
    assign out_load           = (state_reg == S_OUT) && (!out_valid_reg || digest.ready);
    assign digest.valid       = out_valid_reg;
    assign digest.digest_word = out_word_reg;
    assign digest.word_index  = out_idx_reg;
    assign digest.last_word   = out_last_reg;

    assign pos    = count_reg[5:0];
    assign len_hi = count_reg[COUNT_W-1:COUNT_W-32];
    assign len_lo = {count_reg[COUNT_W-33:0], 3'b000};

    always_comb
    begin
        priority if (round_reg < 7'd20)
            phase = 2'd0;
        else if (round_reg < 7'd40)
            phase = 2'd1;
        else if (round_reg < 7'd60)
            phase = 2'd2;
        else
            phase = 2'd3;
        mix   = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
        w_cur = (round_reg < 7'd16) ? win_reg[0] : {mix[30:0], mix[31]};
        temp  = {work_reg[0][26:0], work_reg[0][31:27]}
              + round_f(phase, work_reg[1], work_reg[2], work_reg[3])
              + work_reg[4] + ROUND_K[phase] + w_cur;
        for (int i = 0; i < 5; i++)
            sum[i] = chain_reg[i] + work_reg[i];
    end

    always_comb
    begin
        state_next      = state_reg;
        blk_next        = blk_reg;
        close_pend_next = close_pend_reg;
        count_next      = count_reg;
        chain_next      = chain_reg;
        round_next      = round_reg;
        emit_next       = emit_reg;
        win_next        = win_reg;
        work_next       = work_reg;
        out_word_next   = out_word_reg;
        out_idx_next    = out_idx_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg;

        if (digest.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    if (pop_item.kind == KIND_BYTE || pop_item.kind == KIND_BYTE_CLOSE)
                    begin
                        unique case (pos[1:0])
                            2'd0: win_next[pos[5:2]][31:24] = pop_item.data;
                            2'd1: win_next[pos[5:2]][23:16] = pop_item.data;
                            2'd2: win_next[pos[5:2]][15:8]  = pop_item.data;
                            default: win_next[pos[5:2]][7:0] = pop_item.data;
                        endcase
                        count_next = count_reg + 1'b1;
                    end
                    unique case (pop_item.kind)
                        KIND_BYTE, KIND_BYTE_CLOSE:
                        begin
                            if (pos == 6'd63)
                            begin
                                state_next      = S_ROUND;
                                blk_next        = BLK_DATA;
                                close_pend_next = (pop_item.kind == KIND_BYTE_CLOSE);
                                round_next      = '0;
                                work_next       = chain_reg;
                            end
                            else if (pop_item.kind == KIND_BYTE_CLOSE)
                                state_next = S_PAD;
                        end
                        KIND_CLOSE:
                            state_next = S_PAD;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_PAD:
            begin
                // 0x80 after last byte, zeros; bit length too if pos < 56
                for (int i = 0; i < 16; i++)
                begin
                    if (4'(i) > pos[5:2])
                        win_next[i] = '0;
                    else if (4'(i) == pos[5:2])
                    begin
                        unique case (pos[1:0])
                            2'd0: win_next[i] = {PAD_BYTE, 24'h0};
                            2'd1: win_next[i] = {win_reg[i][31:24], PAD_BYTE, 16'h0};
                            2'd2: win_next[i] = {win_reg[i][31:16], PAD_BYTE, 8'h0};
                            default: win_next[i] = {win_reg[i][31:8], PAD_BYTE};
                        endcase
                    end
                end
                if (pos < 6'd56)
                begin
                    win_next[14] = len_hi;
                    win_next[15] = len_lo;
                    blk_next     = BLK_FINAL;
                end
                else
                    blk_next = BLK_PAD1;
                state_next = S_ROUND;
                round_next = '0;
                work_next  = chain_reg;
            end
            S_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                    win_next[i] = win_reg[i + 1];
                win_next[15] = w_cur;
                work_next[4] = work_reg[3];
                work_next[3] = work_reg[2];
                work_next[2] = {work_reg[1][1:0], work_reg[1][31:2]};
                work_next[1] = work_reg[0];
                work_next[0] = temp;
                round_next   = round_reg + 1'b1;
                if (round_reg == LAST_ROUND)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                chain_next = sum;
                unique case (blk_reg)
                    BLK_DATA:
                        state_next = close_pend_reg ? S_PAD : S_IDLE;
                    BLK_PAD1:
                    begin
                        for (int i = 0; i < 14; i++)
                            win_next[i] = '0;
                        win_next[14] = len_hi;
                        win_next[15] = len_lo;
                        work_next    = sum;
                        round_next   = '0;
                        blk_next     = BLK_FINAL;
                        state_next   = S_ROUND;
                    end
                    default:
                    begin
                        emit_next  = '0;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = chain_reg[emit_reg];
                    out_idx_next   = emit_reg;
                    out_last_next  = (emit_reg == 3'd4);
                    if (emit_reg == 3'd4)
                    begin
                        chain_next = INIT_CHAIN;
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                        emit_next = emit_reg + 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            blk_reg        <= BLK_DATA;
            close_pend_reg <= 1'b0;
            count_reg      <= '0;
            chain_reg      <= INIT_CHAIN;
            round_reg      <= '0;
            emit_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            blk_reg        <= blk_next;
            close_pend_reg <= close_pend_next;
            count_reg      <= count_next;
            chain_reg      <= chain_next;
            round_reg      <= round_next;
            emit_reg       <= emit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg      <= win_next;
        work_reg     <= work_next;
        out_word_reg <= out_word_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

`ifndef NO_ASSERTIONS
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> (round_reg <= LAST_ROUND))
        else $error("round counter past last round");

    a_final_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD && blk_reg == BLK_FINAL) |=> (state_reg == S_OUT))
        else $error("final block did not lead to digest output");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_last_reg == (out_idx_reg == 3'd4)))
        else $error("last_word disagrees with word_index");

    a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> (emit_reg <= 3'd4))
        else $error("digest word counter out of range");
`endif

endmodule

// ===== rtl/sha1_stream_hasher_core.sv =====
`timescale 1ns / 1ps

// Streaming SHA-1. Bytes enter on msg, one per beat, packed big-endian; a beat with
// is_last closes the message (with or without a byte) and the 160-bit digest leaves
// on digest as five 32-bit beats, word 0 first, after which the core is ready for
// the next message. Beats with neither byte nor close are dropped. A small queue
// between the input stage and the hash engine lets bytes keep arriving while a
// block compresses. The engine absorbs one byte per cycle while idle and takes none
// while a block goes through its 80 rounds and the chaining add. Closing takes a
// padding step, one or two blocks (two when 56 or more bytes sit in the final
// block) and five digest beats.
module sha1_stream_hasher_core
    import sha1_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    sha1_msg_if.sink      msg,
    sha1_digest_if.source digest
);

    logic push_valid, push_ready;
    cmd_t push_item;
    logic pop_valid, pop_ready;
    cmd_t pop_item;

    sha1_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg        (msg),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    sha1_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    sha1_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop_ready (pop_ready),
        .digest    (digest)
    );

endmodule
